// File: hdl/adaptive_background_subtractor_unit_macros.svh
// Assertion macros for the adaptive background subtractor.
`ifndef ADAPTIVE_BACKGROUND_SUBTRACTOR_UNIT_MACROS_SVH
`define ADAPTIVE_BACKGROUND_SUBTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ABSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/absu_pkg.sv
// Shared types, constants and helper functions of the background subtractor.
`default_nettype none
package absu_pkg;

  localparam int FRAME_PIXELS = 307200;
  localparam int FRAC_BITS    = 8;
  localparam int IDX_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int PIX_W        = 8;
  localparam int VAL_W        = 24;
  localparam int RATE_W       = 16;
  localparam int KOEF_W       = RATE_W + 1;
  localparam int PROD_W       = VAL_W + KOEF_W;
  localparam int CMP_W        = VAL_W + 2;
  localparam int WIDE_W       = 48;
  localparam int CFG_W        = 16;
  localparam int CFG_ADDR_W   = 3;
  localparam int CHANNELS     = 3;
  localparam int ENTRY_W      = 2 * CHANNELS * VAL_W;

  localparam logic [KOEF_W-1:0] SQRT2_Q16 = KOEF_W'(92682);
  localparam logic [KOEF_W-1:0] ONE_Q16   = KOEF_W'(65536);
  localparam logic [VAL_W-1:0]  VAL_MAX   = '1;

  typedef enum logic [1:0] {
    PH_LEARN_MEAN,
    PH_LEARN_SPREAD,
    PH_DETECT
  } phase_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_INIT_FRAMES     = 3'd0,
    CFG_INIT_RECIPROCAL = 3'd1,
    CFG_BG_RATE         = 3'd2,
    CFG_FG_RATE         = 3'd3,
    CFG_MARGIN          = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    phase_t phase;
    logic   first;
    logic   last;
  } item_ctrl_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] count;
  } learn_state_t;

  function automatic logic [VAL_W-1:0] sat_val(logic [WIDE_W-1:0] v);
    return (v > WIDE_W'(VAL_MAX)) ? VAL_MAX : v[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] round_q16(logic [WIDE_W-1:0] v);
    return sat_val((v + WIDE_W'(32768)) >> 16);
  endfunction

  // Close one learning frame: advance the frame count, move on a phase when full.
  function automatic learn_state_t end_frame(learn_state_t st, logic [7:0] n);
    learn_state_t r;
    logic [7:0]   cnt;
    r   = st;
    cnt = st.count + 8'd1;
    if (st.phase != PH_DETECT) begin
      r.count = cnt;
      if (cnt >= n) begin
        r.count = '0;
        r.phase = (st.phase == PH_LEARN_MEAN) ? PH_LEARN_SPREAD : PH_DETECT;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/absu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module absu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/absu_ctrl.sv
// Pixel index, learning phase and frame counter tracking at the input.
`default_nettype none
module absu_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic                       frame_start,
  input  wire logic [7:0]                 init_frames,
  output logic      [absu_pkg::IDX_W-1:0] idx,
  output absu_pkg::item_ctrl_t            item
);

  logic [absu_pkg::IDX_W-1:0] pixel_index;
  logic [absu_pkg::IDX_W-1:0] pixel_index_next;
  absu_pkg::learn_state_t     lstate;
  absu_pkg::learn_state_t     lstate_mid;
  absu_pkg::learn_state_t     lstate_next;
  logic [7:0]                 n_frames;
  logic [absu_pkg::IDX_W:0]   idx_inc;
  logic                       wrap;

  always_comb begin
    n_frames   = (init_frames == 8'd0) ? 8'd1 : init_frames;
    // A restart part way through a frame closes that frame first.
    lstate_mid = (frame_start && (pixel_index != '0)) ?
                 absu_pkg::end_frame(lstate, n_frames) : lstate;
    idx        = frame_start ? '0 : pixel_index;
    idx_inc    = {1'b0, idx} + (absu_pkg::IDX_W + 1)'(1);
    wrap       = idx_inc >= (absu_pkg::IDX_W + 1)'(absu_pkg::FRAME_PIXELS);
    pixel_index_next = wrap ? '0 : idx_inc[absu_pkg::IDX_W-1:0];
    lstate_next = wrap ? absu_pkg::end_frame(lstate_mid, n_frames) : lstate_mid;
    item.phase = lstate_mid.phase;
    item.first = (lstate_mid.count == 8'd0);
    item.last  = ({1'b0, lstate.count} + 9'd1) >= {1'b0, n_frames};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index  <= '0;
      lstate.phase <= absu_pkg::PH_LEARN_MEAN;
      lstate.count <= '0;
    end else if (accept) begin
      pixel_index <= pixel_index_next;
      lstate      <= lstate_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/absu_lane.sv
// One colour channel of the learn, compare and blend datapath (stages 1 to 4).
`default_nettype none
module absu_lane (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire absu_pkg::item_ctrl_t              ctrl1,
  input  wire absu_pkg::item_ctrl_t              ctrl2,
  input  wire absu_pkg::item_ctrl_t              ctrl3,
  input  wire absu_pkg::item_ctrl_t              ctrl4,
  input  wire logic                              fg3,
  input  wire logic                              fg4,
  input  wire logic [absu_pkg::PIX_W-1:0]        pix1,
  input  wire logic [absu_pkg::VAL_W-1:0]        mean1,
  input  wire logic [absu_pkg::VAL_W-1:0]        sprd1,
  input  wire logic [7:0]                        margin,
  input  wire logic [absu_pkg::RATE_W-1:0]       init_reciprocal,
  input  wire logic [absu_pkg::RATE_W-1:0]       bg_rate,
  input  wire logic [absu_pkg::RATE_W-1:0]       fg_rate,
  output logic                                   fgc2,
  output logic      [absu_pkg::VAL_W-1:0]        mean_new,
  output logic      [absu_pkg::VAL_W-1:0]        sprd_new
);

  localparam int VW = absu_pkg::VAL_W;
  localparam int PW = absu_pkg::PROD_W;
  localparam int CW = absu_pkg::CMP_W;
  localparam int WW = absu_pkg::WIDE_W;
  localparam int KW = absu_pkg::KOEF_W;

  // stage 1
  logic [VW-1:0] x1, d1, msum1;
  logic [CW-1:0] tol1, reach1;
  logic          fgc1;
  // stage 2
  logic [VW-1:0] x2, m2, sp2, msum2, dev2, ssum2;
  logic [PW-1:0] prod2;
  // stage 3
  logic [VW-1:0] x3, m3, sp3, msum3, dev3, ssum3, a_op, c_op;
  logic [KW-1:0] a_k, c_k, rate_s;
  logic [PW-1:0] pa3, pb3, pc3, pd3;
  // stage 4
  logic [VW-1:0] m4, sp4, msum4, ssum4;
  logic [PW-1:0] pa4, pb4, pc4, pd4;

  always_comb begin
    x1     = {{(VW - absu_pkg::PIX_W - absu_pkg::FRAC_BITS){1'b0}}, pix1,
              {absu_pkg::FRAC_BITS{1'b0}}};
    d1     = (x1 > mean1) ? (x1 - mean1) : (mean1 - x1);
    msum1  = absu_pkg::sat_val(WW'(ctrl1.first ? '0 : mean1) + WW'(pix1));
    tol1   = CW'({margin, {absu_pkg::FRAC_BITS{1'b0}}});
    reach1 = CW'(sprd1) + tol1;
    // Outside [mean - reach, mean + reach] on either side.
    fgc1   = ((CW'(x1) + reach1) < CW'(mean1)) || (CW'(x1) > (CW'(mean1) + reach1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2    <= x1;
      m2    <= mean1;
      sp2   <= sprd1;
      msum2 <= msum1;
      prod2 <= PW'(d1) * PW'(absu_pkg::SQRT2_Q16);
      fgc2  <= fgc1;
    end
  end

  always_comb begin
    dev2  = absu_pkg::round_q16(WW'(prod2));
    ssum2 = absu_pkg::sat_val(WW'(ctrl2.first ? '0 : sp2) + WW'(dev2));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3    <= x2;
      m3    <= m2;
      sp3   <= sp2;
      msum3 <= msum2;
      dev3  <= dev2;
      ssum3 <= ssum2;
    end
  end

  always_comb begin
    rate_s = KW'(fg3 ? fg_rate : bg_rate);
    a_op   = (ctrl3.phase == absu_pkg::PH_LEARN_MEAN) ? msum3 : m3;
    a_k    = (ctrl3.phase == absu_pkg::PH_LEARN_MEAN) ? KW'(init_reciprocal) :
             (absu_pkg::ONE_Q16 - KW'(bg_rate));
    c_op   = (ctrl3.phase == absu_pkg::PH_LEARN_SPREAD) ? ssum3 : sp3;
    c_k    = (ctrl3.phase == absu_pkg::PH_LEARN_SPREAD) ? KW'(init_reciprocal) :
             (absu_pkg::ONE_Q16 - rate_s);
    pa3    = PW'(a_op) * PW'(a_k);
    pb3    = PW'(x3) * PW'(bg_rate);
    pc3    = PW'(c_op) * PW'(c_k);
    pd3    = PW'(dev3) * PW'(rate_s);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa4   <= pa3;
      pb4   <= pb3;
      pc4   <= pc3;
      pd4   <= pd3;
      m4    <= m3;
      sp4   <= sp3;
      msum4 <= msum3;
      ssum4 <= ssum3;
    end
  end

  always_comb begin
    unique case (ctrl4.phase)
      absu_pkg::PH_LEARN_MEAN: begin
        mean_new = ctrl4.last ?
                   absu_pkg::sat_val(((WW'(pa4) + WW'(32768)) >> 16) << absu_pkg::FRAC_BITS) :
                   msum4;
        sprd_new = sp4;
      end
      absu_pkg::PH_LEARN_SPREAD: begin
        mean_new = m4;
        sprd_new = ctrl4.last ? absu_pkg::round_q16(WW'(pc4)) : ssum4;
      end
      absu_pkg::PH_DETECT: begin
        mean_new = fg4 ? m4 : absu_pkg::round_q16(WW'(pa4) + WW'(pb4));
        sprd_new = absu_pkg::round_q16(WW'(pc4) + WW'(pd4));
      end
      default: begin
        mean_new = m4;
        sprd_new = sp4;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/adaptive_background_subtractor_unit.sv
// Top level of the adaptive background subtractor: stream ports, config, frame memory.
//
// Pixels arrive in raster order, one transfer per clock, and each gives one result
// transfer after the steps accept, memory read, deviation and compare, blend
// products, round and write back into the output register. The sustained rate is
// one pixel per clock while the output is taken; apart from that, a pixel whose
// memory entry is still in the read-modify-write pipe (same index within the last
// four pixels, which happens only with frames shorter than five pixels or early
// frame restarts) is held off until the earlier write-back has landed.
// The frame memory holds, per pixel, mean and spread for three channels; it is not
// cleared after reset, and an entry is written only when its pixel passes through.
// The first init_frames frames learn the mean, the next init_frames the spread;
// until then results carry learning=1 and foreground=0. The output register holds
// a result until it is taken; while a result is held there the whole pipe stalls
// and no pixel is accepted.
// Config writes take effect at once and are to be made only while the block is idle.
`default_nettype none
`include "adaptive_background_subtractor_unit_macros.svh"
module adaptive_background_subtractor_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // pixel input
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [23:0]                     s_axis_tdata,  // red, green, blue
  input  wire logic                            s_axis_tuser,  // frame_start
  // result output
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [23:0]                     m_axis_tdata,  // out_red, out_green, out_blue
  output logic      [1:0]                      m_axis_tuser,  // foreground, learning
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [absu_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [absu_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int CH = absu_pkg::CHANNELS;
  localparam int VW = absu_pkg::VAL_W;
  localparam int XW = absu_pkg::IDX_W;

  // configuration registers
  logic [7:0]                  init_frames;
  logic [absu_pkg::RATE_W-1:0] init_reciprocal;
  logic [absu_pkg::RATE_W-1:0] bg_rate;
  logic [absu_pkg::RATE_W-1:0] fg_rate;
  logic [7:0]                  margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_frames     <= 8'd50;
      init_reciprocal <= 16'd1311;
      bg_rate         <= 16'd1311;
      fg_rate         <= 16'd328;
      margin          <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        absu_pkg::CFG_INIT_FRAMES:     init_frames     <= cfg_wdata[7:0];
        absu_pkg::CFG_INIT_RECIPROCAL: init_reciprocal <= cfg_wdata;
        absu_pkg::CFG_BG_RATE:         bg_rate         <= cfg_wdata;
        absu_pkg::CFG_FG_RATE:         fg_rate         <= cfg_wdata;
        absu_pkg::CFG_MARGIN:          margin          <= cfg_wdata[7:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // pipeline control
  logic                 en, hazard, accept;
  logic [XW-1:0]        nidx;
  absu_pkg::item_ctrl_t nctrl;
  logic                 v1, v2, v3, v4;
  logic [XW-1:0]        idx1, idx2, idx3, idx4;
  absu_pkg::item_ctrl_t ctrl1, ctrl2, ctrl3, ctrl4;
  logic [23:0]          pix1, pix2, pix3, pix4;
  logic                 fg3, fg4;
  logic [CH-1:0]        fgc2;

  // Advance the whole pipe unless a result sits unread in the output register.
  assign en = !m_axis_tvalid || m_axis_tready;

  // Hold off a pixel whose entry is still being updated further down.
  assign hazard = (v1 && (idx1 == nidx)) || (v2 && (idx2 == nidx)) ||
                  (v3 && (idx3 == nidx)) || (v4 && (idx4 == nidx));
  assign s_axis_tready = en && !hazard;
  assign accept = s_axis_tvalid && s_axis_tready;

  absu_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (s_axis_tuser),
    .init_frames (init_frames),
    .idx         (nidx),
    .item        (nctrl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1  <= nidx;
      ctrl1 <= nctrl;
      pix1  <= s_axis_tdata;
      idx2  <= idx1;
      ctrl2 <= ctrl1;
      pix2  <= pix1;
      idx3  <= idx2;
      ctrl3 <= ctrl2;
      pix3  <= pix2;
      fg3   <= |fgc2;
      idx4  <= idx3;
      ctrl4 <= ctrl3;
      pix4  <= pix3;
      fg4   <= fg3;
    end
  end

  // frame memory: spreads in the upper half, means in the lower half
  logic [absu_pkg::ENTRY_W-1:0] rd_entry, wr_entry;
  logic                         wr_en;

  assign wr_en = en && v4;

  absu_ram #(
    .WIDTH (absu_pkg::ENTRY_W),
    .DEPTH (absu_pkg::FRAME_PIXELS)
  ) u_frame_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx4),
    .wdata (wr_entry),
    .re    (accept),
    .raddr (nidx),
    .rdata (rd_entry)
  );

  for (genvar c = 0; c < CH; c++) begin : g_lane
    absu_lane u_lane (
      .clk             (clk),
      .en              (en),
      .ctrl1           (ctrl1),
      .ctrl2           (ctrl2),
      .ctrl3           (ctrl3),
      .ctrl4           (ctrl4),
      .fg3             (fg3),
      .fg4             (fg4),
      .pix1            (pix1[c*8 +: 8]),
      .mean1           (rd_entry[c*VW +: VW]),
      .sprd1           (rd_entry[(CH + c)*VW +: VW]),
      .margin          (margin),
      .init_reciprocal (init_reciprocal),
      .bg_rate         (bg_rate),
      .fg_rate         (fg_rate),
      .fgc2            (fgc2[c]),
      .mean_new        (wr_entry[c*VW +: VW]),
      .sprd_new        (wr_entry[(CH + c)*VW +: VW])
    );
  end

  // output register
  logic out_fg;

  assign out_fg = (ctrl4.phase == absu_pkg::PH_DETECT) && fg4;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v4) begin
      m_axis_tdata <= out_fg ? pix4 : '0;
      m_axis_tuser <= {ctrl4.phase != absu_pkg::PH_DETECT, out_fg};
    end
  end

  // An item in the first stage never shares its memory entry with the item just ahead of it.
  `ABSU_ASSERT_NOW(a_no_shared_entry, v1 && v2, idx1 != idx2, "entry shared in pipe")
  // An accepted pixel enters the first stage.
  `ABSU_ASSERT_NEXT(a_accept_enters, accept, v1, "accepted pixel lost")
  // No foreground mask while still learning.
  `ABSU_ASSERT_NOW(a_learn_no_fg, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0], "foreground during learning")

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the adaptive background subtractor unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int LINE_PIXELS = 12;   // longest frame sent in every test; also the depth of the model memories
  localparam int WATCHDOG    = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic       foreground;
    logic       learning;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_result_t;

  logic                       clk;
  logic                       rst;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [23:0]                s_axis_tdata;   // red, green, blue
  logic                       s_axis_tuser;   // frame_start
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [23:0]                m_axis_tdata;   // out_red, out_green, out_blue
  logic [1:0]                 m_axis_tuser;   // foreground, learning
  logic                       cfg_we;
  absu_pkg::cfg_idx_t         cfg_addr;
  logic [absu_pkg::CFG_W-1:0] cfg_wdata;

  adaptive_background_subtractor_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Own copy of the block's settings and state.
  logic [7:0]       frames_per_phase;
  logic [15:0]      learn_scale, bg_rate, fg_rate;
  logic [7:0]       margin;
  logic [23:0]      mean_mem [0:LINE_PIXELS-1][0:2];
  logic [23:0]      spread_mem [0:LINE_PIXELS-1][0:2];
  absu_pkg::phase_t phase;
  logic [7:0]       frame_count;
  int               pix_idx;

  pixel_result_t pending_results[$];
  logic [23:0]   scene [0:LINE_PIXELS-1];
  int            mismatches = 0;
  int            src_idle_pct = 0;
  int            snk_stall_pct = 0;
  bit            hold_request = 0;
  int            quiet_cycles = 0;
  bit            in_xfer, out_xfer;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [23:0] sat24(logic [63:0] v);
    return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

  function automatic logic [23:0] blend(logic [23:0] old, logic [23:0] src, logic [15:0] r);
    logic [63:0] v;
    v = 64'(old) * (64'd65536 - 64'(r)) + 64'(src) * 64'(r) + 64'd32768;
    return sat24(v >> 16);
  endfunction

  function automatic logic [23:0] deviation(logic [23:0] x, logic [23:0] m);
    logic [63:0] d;
    d = (x > m) ? 64'(x - m) : 64'(m - x);
    return sat24((d * 64'd92682 + 64'd32768) >> 16);
  endfunction

  // Close a frame: count it and move on a phase when the learning span is done.
  function automatic void close_frame();
    logic [7:0] n;
    n = (frames_per_phase == 0) ? 8'd1 : frames_per_phase;
    if (phase == absu_pkg::PH_DETECT) return;
    frame_count = frame_count + 8'd1;
    if (frame_count >= n) begin
      phase       = (phase == absu_pkg::PH_LEARN_MEAN) ? absu_pkg::PH_LEARN_SPREAD :
                                                         absu_pkg::PH_DETECT;
      frame_count = '0;
    end
  endfunction

  function automatic pixel_result_t subtract_pixel(logic [23:0] rgb, logic fs);
    pixel_result_t res;
    logic [7:0]    n;
    bit            last, fg;
    logic [63:0]   acc;
    logic [23:0]   x, dev [0:2];
    longint        xs, m, s, tol;
    n    = (frames_per_phase == 0) ? 8'd1 : frames_per_phase;
    last = (9'(frame_count) + 9'd1 >= 9'(n));
    fg   = 0;
    res  = '{1'b0, 1'b0, 8'd0, 8'd0, 8'd0};
    if (fs) begin
      if (pix_idx != 0) close_frame();
      pix_idx = 0;
    end
    if (phase == absu_pkg::PH_LEARN_MEAN) begin
      for (int c = 0; c < 3; c++) begin
        acc = (frame_count == 0) ? 64'd0 : 64'(mean_mem[pix_idx][c]);
        acc = sat24(acc + 64'(rgb[8*c +: 8]));
        if (last)
          acc = sat24(((acc * 64'(learn_scale) + 64'd32768) >> 16) << absu_pkg::FRAC_BITS);
        mean_mem[pix_idx][c] = acc[23:0];
      end
      res.learning = 1'b1;
    end else if (phase == absu_pkg::PH_LEARN_SPREAD) begin
      for (int c = 0; c < 3; c++) begin
        x   = 24'(rgb[8*c +: 8]) << absu_pkg::FRAC_BITS;
        acc = (frame_count == 0) ? 64'd0 : 64'(spread_mem[pix_idx][c]);
        acc = sat24(acc + 64'(deviation(x, mean_mem[pix_idx][c])));
        if (last) acc = sat24((acc * 64'(learn_scale) + 64'd32768) >> 16);
        spread_mem[pix_idx][c] = acc[23:0];
      end
      res.learning = 1'b1;
    end else begin
      tol = longint'(margin) <<< absu_pkg::FRAC_BITS;
      for (int c = 0; c < 3; c++) begin
        xs = longint'(rgb[8*c +: 8]) <<< absu_pkg::FRAC_BITS;
        m  = longint'(mean_mem[pix_idx][c]);
        s  = longint'(spread_mem[pix_idx][c]);
        if (xs < m - s - tol || xs > m + s + tol) fg = 1;
        dev[c] = deviation(24'(xs), mean_mem[pix_idx][c]);
      end
      for (int c = 0; c < 3; c++) begin
        x = 24'(rgb[8*c +: 8]) << absu_pkg::FRAC_BITS;
        if (fg) begin
          spread_mem[pix_idx][c] = blend(spread_mem[pix_idx][c], dev[c], fg_rate);
        end else begin
          mean_mem[pix_idx][c]   = blend(mean_mem[pix_idx][c], x, bg_rate);
          spread_mem[pix_idx][c] = blend(spread_mem[pix_idx][c], dev[c], bg_rate);
        end
      end
      if (fg) res = '{1'b1, 1'b0, rgb[7:0], rgb[15:8], rgb[23:16]};
    end
    pix_idx++;
    if (pix_idx >= absu_pkg::FRAME_PIXELS) begin
      pix_idx = 0;
      close_frame();
    end
    return res;
  endfunction

  // Offer one pixel, hold it until the transfer, then predict its result.
  task automatic send_pixel(logic [23:0] rgb, logic fs);
    bit rdy;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rgb;
    s_axis_tuser  <= fs;
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    pending_results.push_back(subtract_pixel(rgb, fs));
  endtask

  function automatic logic [23:0] near_scene(int i);
    logic [23:0] p;
    int          v;
    if ($urandom_range(99) < 25) return 24'($urandom);
    for (int c = 0; c < 3; c++) begin
      v = int'(scene[i][8*c +: 8]) + $urandom_range(12) - 6;
      p[8*c +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    end
    return p;
  endfunction

  task automatic send_frame(int len);
    for (int i = 0; i < len; i++) send_pixel(near_scene(i), i == 0);
  endtask

  // Random frames, mostly of four pixels up to a full line, else of one to three pixels.
  task automatic send_frames(int pixels);
    int len;
    while (pixels > 0) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, LINE_PIXELS);
      send_frame(len);
      pixels -= len;
    end
  endtask

  // Drain every expected result, then allow the pipe to empty.
  task automatic wait_drained();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_settings(logic [7:0] nf, logic [15:0] rcp, logic [15:0] bgr,
                               logic [15:0] fgr, logic [7:0] mg);
    absu_pkg::cfg_idx_t idx;
    logic [15:0]        val;
    for (int i = 0; i < 5; i++) begin
      idx = absu_pkg::cfg_idx_t'(i);
      case (idx)
        absu_pkg::CFG_INIT_FRAMES:     val = 16'(nf);
        absu_pkg::CFG_INIT_RECIPROCAL: val = rcp;
        absu_pkg::CFG_BG_RATE:         val = bgr;
        absu_pkg::CFG_FG_RATE:         val = fgr;
        default:                       val = 16'(mg);
      endcase
      cfg_we    <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    frames_per_phase = nf;
    learn_scale      = rcp;
    bg_rate          = bgr;
    fg_rate          = fgr;
    margin           = mg;
  endtask

  // Learn the mean over two frames and the spread over one, then detect with a zero frame count.
  task automatic test_learning();
    load_settings(8'd255, 16'd21845, 16'd1311, 16'd328, 8'd10);
    for (int i = 0; i < LINE_PIXELS; i++)
      send_pixel(near_scene(i), (i == 0) && $urandom_range(1));
    send_frame($urandom_range(1, LINE_PIXELS));
    wait_drained();
    // lowering the frame count mid-phase ends the mean phase at the next frame start
    load_settings(8'd1, 16'd21845, 16'd1311, 16'd328, 8'd10);
    send_frame(LINE_PIXELS);
    wait_drained();
    load_settings(8'd0, 16'd65535, 16'd1311, 16'd328, 8'd10);
    send_frame(LINE_PIXELS);
    wait_drained();
  endtask

  // Channel extremes against the learned background, in short frames.
  task automatic test_extremes();
    logic [23:0] rgb [0:7];
    rgb = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
            24'hFF0000, 24'hFF00FF, 24'h808080, 24'h7F7F7F};
    load_settings(8'd0, 16'd0, 16'd0, 16'd65535, 8'd0);
    for (int i = 0; i < 8; i++) send_pixel(rgb[i], i == 0);
    for (int i = 0; i < 8; i++) send_pixel(scene[i], i == 0);
    send_pixel(24'hFFFFFF, 1'b1);   // one-pixel frames back to back
    send_pixel(24'h000000, 1'b1);
    send_pixel(scene[0], 1'b1);
    wait_drained();
    load_settings(8'd255, 16'd65535, 16'd65535, 16'd0, 8'd255);
    for (int i = 0; i < 6; i++) send_pixel(rgb[i], i == 0);
    wait_drained();
  endtask

  // Random frames across idle patterns and rate settings.
  task automatic test_random_frames();
    int idle [0:3][0:1];
    idle = '{'{0, 0}, '{64, 0}, '{0, 64}, '{19, 19}};
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       load_settings(8'd50, 16'd1311, 16'd1311, 16'd328, 8'd10);
        1:       load_settings(8'd1, 16'd1, 16'd65535, 16'd0, 8'd0);
        2:       load_settings(8'd50, 16'd65535, 16'd0, 16'd65535, 8'd3);
        default: load_settings(8'($urandom), 16'($urandom), 16'($urandom_range(4000)),
                               16'($urandom_range(4000)), 8'($urandom_range(20)));
      endcase
      src_idle_pct  = idle[p][0];
      snk_stall_pct = idle[p][1];
      send_frames(200);
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      send_frames(200);
      wait_drained();
    end
  endtask

  // Hold the output off while pixels keep coming, then run with random stalls on both sides.
  task automatic test_backpressure();
    load_settings(8'd50, 16'd1311, 16'd1311, 16'd328, 8'd10);
    hold_request = 1;
    send_frames(60);
    send_frames(40);
    wait_drained();
    snk_stall_pct = 30;
    src_idle_pct  = 30;
    send_frames(100);
    wait_drained();
  endtask

  // Output ready: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    static int hold_left = 0;
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Sample between edges, where every signal is settled.
  always @(negedge clk) begin
    in_xfer  = s_axis_tvalid && s_axis_tready && !rst;
    out_xfer = m_axis_tvalid && m_axis_tready && !rst;
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    pixel_result_t want;
    if (out_xfer) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== {want.learning, want.foreground} ||
            m_axis_tdata !== {want.blue, want.green, want.red}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected learning=%b fg=%b rgb=%h, got tuser=%b rgb=%h",
                     want.learning, want.foreground, {want.blue, want.green, want.red},
                     m_axis_tuser, m_axis_tdata);
        end
      end
    end
    quiet_cycles = (in_xfer || out_xfer) ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("adaptive_background_subtractor_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = absu_pkg::CFG_INIT_FRAMES;
    cfg_wdata     = '0;
    frames_per_phase = 8'd50;
    learn_scale      = 16'd1311;
    bg_rate          = 16'd1311;
    fg_rate          = 16'd328;
    margin           = 8'd10;
    phase            = absu_pkg::PH_LEARN_MEAN;
    frame_count      = '0;
    pix_idx          = 0;
    foreach (mean_mem[i, c]) begin
      mean_mem[i][c]   = '0;
      spread_mem[i][c] = '0;
    end
    foreach (scene[i]) scene[i] = 24'($urandom);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_learning();
    test_extremes();
    test_random_frames();
    test_backpressure();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("adaptive_background_subtractor_unit regression: pass");
    end else begin
      $display("adaptive_background_subtractor_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
